// ===== rtl/core/swq_pkg.sv =====
// ----------------------------------------------------------------------------
// swq_pkg: shared types for the semaphore wait queue table
// Command codes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package swq_pkg;

    typedef enum logic [1:0] {
        CMD_BLOCK  = 2'd0,
        CMD_WAKE   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DSCAN,
        S_DWALK,
        S_DFIX,
        S_SCAN,
        S_EXEC,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input transaction
        logic scan_wk;   // start key scan on waiting key of proc
        logic scan_in;   // start key scan on input key
        logic scan_step; // advance key scan by one descriptor
        logic walk_init; // start queue walk at head
        logic walk_step; // advance queue walk
        logic detach;    // unlink the found process
        logic exec;      // perform the command proper
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic scan_hit;
        logic walk_done;
        logic walk_hit;
        logic pid_ok;
    } sts_t;

endpackage

// ===== rtl/core/swq_datapath.sv =====
// ----------------------------------------------------------------------------
// swq_datapath: descriptor tables, process link tables and scanning counters
// Key scan and queue walk each advance one entry per cycle.
// ----------------------------------------------------------------------------
module swq_datapath #(
    parameter int MAX_PROCS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swq_pkg::ctl_t       ctl,
    output swq_pkg::sts_t       sts,
    input  logic [1:0]          in_cmd,
    input  logic [31:0]         in_key,
    input  logic [4:0]          in_pid,
    output logic [1:0]          out_status,
    output logic [4:0]          out_proc
);
    import swq_pkg::*;

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PW = $clog2(MAX_PROCS + 1);
    localparam logic [PW-1:0] END_MARK = PW'(MAX_PROCS);

    logic [MAX_PROCS-1:0] in_use_reg, in_use_next;
    logic [31:0]   slot_key  [MAX_PROCS];
    logic [PW-1:0] slot_head [MAX_PROCS];
    logic [PW-1:0] slot_tail [MAX_PROCS];
    logic [PW-1:0] proc_next [MAX_PROCS];
    logic [31:0]   wait_key_reg [MAX_PROCS];

    logic [1:0]    cmd_reg;
    logic [31:0]   key_reg;
    logic [4:0]    pid_reg;
    logic [31:0]   skey_reg;
    logic [PW-1:0] sidx_reg;
    logic          hit_reg;
    logic [IW-1:0] slot_reg;
    logic [PW-1:0] cur_reg, prev_reg;
    logic [PW-1:0] steps_reg;
    logic          whit_reg;
    logic [1:0]    status_reg;
    logic [4:0]    res_reg;

    logic          pid_ok;
    logic [IW-1:0] pidx;
    logic [IW-1:0] sidx;
    logic          cur_ok;
    logic [IW-1:0] cidx, pvidx;
    logic [IW-1:0] free_idx;
    logic          free_ok;
    logic [1:0]    exec_status;
    logic [4:0]    exec_res;

    assign pid_ok = (32'(pid_reg) < 32'(MAX_PROCS));
    assign pidx   = IW'(pid_reg);
    assign sidx   = sidx_reg[IW-1:0];
    assign cur_ok = (cur_reg < END_MARK);
    assign cidx   = cur_reg[IW-1:0];
    assign pvidx  = prev_reg[IW-1:0];

    // lowest free descriptor (priority encoder over valid bits)
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_idx = IW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    assign sts.scan_done = hit_reg || (sidx_reg >= END_MARK);
    assign sts.scan_hit  = hit_reg;
    assign sts.walk_done = whit_reg || !cur_ok || (steps_reg >= END_MARK);
    assign sts.walk_hit  = whit_reg;
    assign sts.pid_ok    = pid_ok;
    assign out_status    = status_reg;
    assign out_proc      = res_reg;

    always_comb begin
        in_use_next = in_use_reg;
        if (ctl.detach && slot_head[slot_reg] == cur_reg && proc_next[cidx] >= END_MARK
            && !(prev_reg < END_MARK))
            in_use_next[slot_reg] = 1'b0;
        if (ctl.exec) begin
            case (cmd_t'(cmd_reg))
                CMD_BLOCK: if (pid_ok && !hit_reg && free_ok) in_use_next[free_idx] = 1'b1;
                CMD_WAKE: if (hit_reg && slot_head[slot_reg] < END_MARK
                              && proc_next[slot_head[slot_reg][IW-1:0]] >= END_MARK)
                    in_use_next[slot_reg] = 1'b0;
                default: ;
            endcase
        end
    end

    // response of the command proper
    always_comb begin
        exec_status = ST_NOTFOUND;
        exec_res    = '0;
        case (cmd_t'(cmd_reg))
            CMD_BLOCK: begin
                if (pid_ok) exec_status = (hit_reg || free_ok) ? ST_OK : ST_FULL;
            end
            CMD_WAKE: begin
                if (hit_reg && slot_head[slot_reg] < END_MARK) begin
                    exec_status = ST_OK;
                    exec_res    = 5'(slot_head[slot_reg]);
                end
            end
            CMD_REMOVE: begin
                if (pid_ok && whit_reg) begin
                    exec_status = ST_OK;
                    exec_res    = pid_reg;
                end
            end
            default: begin
                if (hit_reg && slot_head[slot_reg] < END_MARK) begin
                    exec_status = ST_OK;
                    exec_res    = 5'(slot_head[slot_reg]);
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            for (int i = 0; i < MAX_PROCS; i++) wait_key_reg[i] <= '0;
        end else begin
            in_use_reg <= in_use_next;
            if (ctl.exec && cmd_t'(cmd_reg) == CMD_BLOCK && pid_ok && (hit_reg || free_ok))
                wait_key_reg[pidx] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
            pid_reg <= in_pid;
        end
        if (ctl.scan_wk || ctl.scan_in) begin
            skey_reg <= ctl.scan_wk ? wait_key_reg[pidx] : key_reg;
            sidx_reg <= '0;
            hit_reg  <= 1'b0;
        end else if (ctl.scan_step) begin
            if (in_use_reg[sidx] && slot_key[sidx] == skey_reg) begin
                hit_reg  <= 1'b1;
                slot_reg <= sidx;
            end else begin
                sidx_reg <= sidx_reg + PW'(1);
            end
        end
        if (ctl.walk_init) begin
            cur_reg   <= slot_head[slot_reg];
            prev_reg  <= END_MARK;
            steps_reg <= '0;
            whit_reg  <= 1'b0;
        end else if (ctl.walk_step) begin
            if (cur_reg == PW'(pid_reg)) begin
                whit_reg <= 1'b1;
            end else begin
                prev_reg  <= cur_reg;
                cur_reg   <= proc_next[cidx];
                steps_reg <= steps_reg + PW'(1);
            end
        end
        if (ctl.detach) begin
            if (prev_reg < END_MARK) proc_next[pvidx] <= proc_next[cidx];
            else                     slot_head[slot_reg] <= proc_next[cidx];
            if (slot_tail[slot_reg] == cur_reg) slot_tail[slot_reg] <= prev_reg;
        end
        if (ctl.exec) begin
            status_reg <= exec_status;
            res_reg    <= exec_res;
            case (cmd_t'(cmd_reg))
                CMD_BLOCK: begin
                    if (pid_ok && hit_reg) begin
                        if (slot_tail[slot_reg] < END_MARK)
                            proc_next[slot_tail[slot_reg][IW-1:0]] <= PW'(pid_reg);
                        else
                            slot_head[slot_reg] <= PW'(pid_reg);
                        slot_tail[slot_reg] <= PW'(pid_reg);
                        proc_next[pidx]     <= END_MARK;
                    end else if (pid_ok && free_ok) begin
                        slot_key[free_idx]  <= key_reg;
                        slot_head[free_idx] <= PW'(pid_reg);
                        slot_tail[free_idx] <= PW'(pid_reg);
                        proc_next[pidx]     <= END_MARK;
                    end
                end
                CMD_WAKE: begin
                    if (hit_reg && slot_head[slot_reg] < END_MARK) begin
                        slot_head[slot_reg] <= proc_next[slot_head[slot_reg][IW-1:0]];
                        if (proc_next[slot_head[slot_reg][IW-1:0]] >= END_MARK)
                            slot_tail[slot_reg] <= END_MARK;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/swq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swq_ctrl: command sequencer
// Steps through detach, key scan and execution for one transaction.
// ----------------------------------------------------------------------------
module swq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_cmd,
    output logic           m_valid,
    input  logic           m_ready,
    input  swq_pkg::sts_t  sts,
    output swq_pkg::ctl_t  ctl
);
    import swq_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
        if (s_valid && s_ready) cmd_reg <= s_cmd;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                state_next = (cmd_t'(s_cmd) == CMD_BLOCK || cmd_t'(s_cmd) == CMD_REMOVE)
                             ? S_DSCAN : S_SCAN;
            end
            S_DSCAN: begin
                if (!sts.pid_ok)        state_next = S_EXEC;
                else if (sts.scan_done) state_next = sts.scan_hit ? S_DWALK
                    : (cmd_t'(cmd_reg) == CMD_BLOCK ? S_SCAN : S_EXEC);
            end
            S_DWALK: if (sts.walk_done) begin
                if (sts.walk_hit) state_next = S_DFIX;
                else state_next = (cmd_t'(cmd_reg) == CMD_BLOCK) ? S_SCAN : S_EXEC;
            end
            S_DFIX: state_next = (cmd_t'(cmd_reg) == CMD_BLOCK) ? S_SCAN : S_EXEC;
            S_SCAN: if (sts.scan_done) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctl     = '0;
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE: begin
                ctl.load    = s_valid;
            end
            S_DSCAN: begin
                ctl.scan_step = 1'b1;
                ctl.walk_init = sts.scan_done;
                // old key not in the table: block goes straight to its own key
                ctl.scan_in   = sts.pid_ok && sts.scan_done && !sts.scan_hit
                                && (cmd_t'(cmd_reg) == CMD_BLOCK);
            end
            S_DWALK: begin
                ctl.walk_step = !sts.walk_done;
                ctl.scan_in   = sts.walk_done && !sts.walk_hit;
            end
            S_DFIX: begin
                ctl.detach  = 1'b1;
                ctl.scan_in = 1'b1;
            end
            S_SCAN: ctl.scan_step = 1'b1;
            S_EXEC: ctl.exec = 1'b1;
            default: ;
        endcase
        // the first scan is armed by the top level; scan_wk stays low here
        if (state_reg == S_IDLE && s_valid) begin
            ctl.scan_wk = 1'b0;
        end
    end

    // scan start signals depend on the captured command and are issued in the cycle after the load
    // (handled by the top level arming register)
endmodule

// ===== rtl/core/semaphore_wait_queue_table_core.sv =====
// ----------------------------------------------------------------------------
// semaphore_wait_queue_table_core: active semaphore list
// Table of semaphore descriptors, each with a key and a FIFO of blocked
// processes.
//
// Input channel s_*: one command transaction (cmd, sem_key, proc_id).
// Result channel m_*: one transaction (status, result_proc) per command.
// A transaction is taken only while idle; the result is held on m_* until
// accepted, after which the next command is taken.
// Sequence: peek/wake scan for the input key, one descriptor a cycle;
// block and remove first scan for the process's old key and walk up to
// MAX_PROCS links of its queue; block then scans for its input key.
// A stalled receiver simply holds the block in its output state.
// Reset (aresetn low, synchronous) frees all descriptors and clears every
// waiting key; no clearing pass is needed.
// ----------------------------------------------------------------------------
module semaphore_wait_queue_table_core #(
    parameter int MAX_PROCS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_sem_key,
    input  logic [4:0]  s_proc_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_result_proc
);
    import swq_pkg::*;

    ctl_t ctl_c, ctl;
    sts_t sts;
    logic arm_reg;
    logic blk_rem_reg;

    // first scan of a transaction: waiting key for block/remove, else input key
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_reg <= 1'b0;
        end else begin
            arm_reg <= ctl_c.load;
        end
        if (ctl_c.load)
            blk_rem_reg <= (cmd_t'(s_cmd) == CMD_BLOCK || cmd_t'(s_cmd) == CMD_REMOVE);
    end

    always_comb begin
        ctl = ctl_c;
        if (arm_reg) begin
            ctl.scan_step = 1'b0;
            ctl.walk_init = 1'b0;
            ctl.scan_wk   = blk_rem_reg;
            ctl.scan_in   = !blk_rem_reg;
        end
    end

    // hold the controller in the cycle after load so the scan is armed first
    sts_t sts_c;
    always_comb begin
        sts_c = sts;
        if (arm_reg) begin
            sts_c.scan_done = 1'b0;
            sts_c.pid_ok    = 1'b1;
        end
    end

    swq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts_c),
        .ctl     (ctl_c)
    );

    swq_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (s_cmd),
        .in_key     (s_sem_key),
        .in_pid     (s_proc_id),
        .out_status (m_status),
        .out_proc   (m_result_proc)
    );

endmodule
